### src/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map for the base64 line encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam logic [7:0] GPL_RESET  = 8'd19;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } out_t;

  // One byte's worth of output work, as handed from the front to the back.
  typedef struct packed {
    logic       nl;     // newline leads the characters
    logic [5:0] code0;  // first code, always present
    logic [5:0] code1;  // second code
    logic       two;    // code1 is present
    logic [1:0] pads;   // trailing pad characters
    logic       last;   // final character closes the message
  } job_t;

  // Maps a six-bit code onto the standard base64 alphabet.
  function automatic logic [7:0] code_to_char(input logic [5:0] code);
    logic [7:0] c;
    c = {2'b00, code};
    if (code < 6'd26) begin
      return CHAR_UPPER + c;
    end else if (code < 6'd52) begin
      return CHAR_LOWER + c - 8'd26;
    end else if (code < 6'd62) begin
      return CHAR_DIGIT + c - 8'd52;
    end else if (code == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

### src/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks group phase and line fill, and emits one job per byte.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  b64e_pkg::in_t  in_data,
  input  logic [7:0]     groups_per_line,
  output b64e_pkg::job_t job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;
  logic [7:0] line_r, line_nxt;
  logic [7:0] b;
  logic       last;

  assign b    = in_data.data_byte;
  assign last = in_data.last_byte;

  always_comb begin
    job       = '0;
    job.last  = last;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    line_nxt  = line_r;
    case (phase_r)
      2'd1: begin
        job.code0 = {left_r[1:0], b[7:4]};
        job.code1 = {b[3:0], 2'b00};
        job.two   = last;
        job.pads  = last ? 2'd1 : 2'd0;
        left_nxt  = b[3:0];
        phase_nxt = 2'd2;
      end
      2'd2: begin
        job.code0 = {left_r, b[7:6]};
        job.code1 = b[5:0];
        job.two   = 1'b1;
        left_nxt  = 4'd0;
        phase_nxt = 2'd0;
      end
      default: begin
        if (line_r != 8'd0 && line_r >= groups_per_line) begin
          job.nl   = 1'b1;
          line_nxt = 8'd1;
        end else begin
          line_nxt = line_r + 8'd1;
        end
        job.code0 = b[7:2];
        job.code1 = {b[1:0], 4'b0000};
        job.two   = last;
        job.pads  = last ? 2'd2 : 2'd0;
        left_nxt  = {2'b00, b[1:0]};
        phase_nxt = 2'd1;
      end
    endcase
    if (last) begin
      phase_nxt = 2'd0;
      left_nxt  = 4'd0;
      line_nxt  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      left_r  <= 4'd0;
      line_r  <= 8'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      line_r  <= line_nxt;
    end
  end

  phase_legal_a: assert property (@(posedge clk) disable iff (!rst_n) phase_r != 2'd3)
    else $error("front group phase reached an unused value");

endmodule

### src/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo
// Short job queue that decouples the byte front from the character back.
// ----------------------------------------------------------------------------
module b64e_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  b64e_pkg::job_t wr_data,
  input  logic           rd,
  output b64e_pkg::job_t rd_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  b64e_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;

  assign full    = (cnt_r == DEPTH_C);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
      end
      if (rd) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  cnt_bound_a: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= DEPTH_C)
    else $error("job queue count exceeds its depth");

  no_overrun_a: assert property (@(posedge clk) disable iff (!rst_n) !(wr && full))
    else $error("job written into a full queue");

  no_underrun_a: assert property (@(posedge clk) disable iff (!rst_n) !(rd && empty))
    else $error("job read from an empty queue");

endmodule

### src/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks each job one character per cycle into the output register when free.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic            clk,
  input  logic            rst_n,
  input  b64e_pkg::job_t  job,
  input  logic            job_avail,
  output logic            job_done,
  input  logic            pop,
  output logic            empty,
  output b64e_pkg::out_t  out_data
);

  logic [2:0]     slot_r;
  logic [2:0]     len;
  logic [2:0]     k;
  logic           final_slot;
  logic           emit;
  logic           out_valid_r;
  b64e_pkg::out_t out_r;
  b64e_pkg::out_t cur;

  assign len        = 3'(job.nl) + 3'd1 + 3'(job.two) + 3'(job.pads);
  assign k          = slot_r - 3'(job.nl);
  assign final_slot = (slot_r == len - 3'd1);
  assign emit       = job_avail && (!out_valid_r || pop);
  assign job_done   = emit && final_slot;

  always_comb begin
    cur.out_last = job.last && final_slot;
    if (job.nl && slot_r == 3'd0) begin
      cur.out_char = b64e_pkg::CHAR_NL;
    end else if (k == 3'd0) begin
      cur.out_char = b64e_pkg::code_to_char(job.code0);
    end else if (k == 3'd1 && job.two) begin
      cur.out_char = b64e_pkg::code_to_char(job.code1);
    end else begin
      cur.out_char = b64e_pkg::CHAR_PAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        slot_r <= final_slot ? 3'd0 : slot_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= cur;
    end
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  slot_in_job_a: assert property (@(posedge clk) disable iff (!rst_n)
      job_avail |-> slot_r < len)
    else $error("character slot ran past the end of its job");

  idle_slot_a: assert property (@(posedge clk) disable iff (!rst_n)
      !job_avail |-> slot_r == 3'd0)
    else $error("character slot left mid-job with no job queued");

endmodule

### src/base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Byte-in, character-out base64 encoder with newline insertion per line.
// ----------------------------------------------------------------------------
// Bytes enter through a queue-style port (push/full) and encoded characters
// leave through another (empty/pop). Every byte gives one to five characters:
// an optional leading newline once a line holds groups_per_line groups, one or
// two alphabet characters, and on the byte marked last zero to two '=' pads;
// the final character of a message carries out_last. The output side moves
// one character per clock while pop keeps the output register drained, so the
// sustained byte rate is set by how many characters each byte gives. The front
// takes one byte per cycle until the job queue of JOB_DEPTH entries fills.
// groups_per_line is written through the cfg port, which is always ready,
// and should only be changed while the encoder is idle.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder #(
  parameter int JOB_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  b64e_pkg::in_t   in_data,
  output logic            empty,
  input  logic            pop,
  output b64e_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [7:0]      cfg_data
);

  logic           gpl_wr;
  logic [7:0]     gpl_r;
  logic           accept;
  b64e_pkg::job_t front_job;
  b64e_pkg::job_t head_job;
  logic           q_empty;
  logic           job_done;

  // The configuration channel never stalls; a write transaction lands at once.
  assign cfg_ready = 1'b1;
  assign gpl_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= b64e_pkg::GPL_RESET;
    end else if (gpl_wr) begin
      gpl_r <= cfg_data;
    end
  end

  // An input transaction completes whenever the job queue has room.
  assign accept = push && !full;

  // The front classifies each byte into a job and keeps the group state.
  b64e_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .in_data         (in_data),
    .groups_per_line (gpl_r),
    .job             (front_job)
  );

  // The queue lets the front run ahead while the back drains characters.
  b64e_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (accept),
    .wr_data (front_job),
    .rd      (job_done),
    .rd_data (head_job),
    .full    (full),
    .empty   (q_empty)
  );

  // The back emits one character per cycle into its output register when free.
  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_avail (!q_empty),
    .job_done  (job_done),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

  gpl_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
      !gpl_wr |=> gpl_r == $past(gpl_r))
    else $error("line length changed without a configuration transaction");

endmodule
